[src/nfaec_pkg.sv]
// Shared types, constants and helpers for the epsilon-closure automaton matcher.
// Used by nfa_epsilon_closure_matcher and its bench; depends on nothing.
package nfaec_pkg;

	localparam int STATE_LIMIT     = 32;
	localparam int MAX_TRANSITIONS = 256;

	localparam int STATE_W  = 5;
	localparam int SYMBOL_W = 8;
	localparam int SET_W    = 32;
	localparam int ENTRY_W  = 2 * STATE_W + SYMBOL_W;
	localparam int TOTAL_W  = 9;
	localparam int SCNT_W   = 6;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;

	localparam logic [SYMBOL_W-1:0] EPSILON_SYMBOL = '0;

	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_BEGIN   = 2'd1;
	localparam logic [1:0] ACT_CONSUME = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_START_MASK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	// Closure of the current set, one pass for the symbol, closure of the targets
	typedef enum logic [2:0] {
		PH_CLOS1 = 3'b001,
		PH_STEP  = 3'b010,
		PH_CLOS2 = 3'b100
	} phase_t;

	// Bits of the states in use: the lowest min(state_count, STATE_LIMIT) bits
	function automatic logic [SET_W-1:0] live_mask(input logic [SCNT_W-1:0] sc);
		logic [6:0] n;
		n = (7'(sc) > 7'(STATE_LIMIT)) ? 7'(STATE_LIMIT) : 7'(sc);
		if (n >= 7'(SET_W))
			return '1;
		else
			return (SET_W'(1) << n[4:0]) - SET_W'(1);
	endfunction

endpackage

[src/nfaec_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module nfaec_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[src/nfa_epsilon_closure_matcher.sv]
// Epsilon-closure automaton matcher: transition list in nfaec_ram, sequencer walks it.
// Depends on nfaec_pkg and nfaec_ram.
//
// An add, an epsilon consume or an unknown action goes straight to S_OUT, which
// registers the result once the output is free. A begin runs closure passes over the
// list until a pass adds no state, up to 32 passes, then goes to S_OUT. A consume runs
// closure passes, one symbol pass and closure passes again, then goes to S_OUT.
// One item at a time; the list memory read port sets the pace. Reset clears the count,
// the active set and the masks, sets the state count to 32; the list needs no clearing.
module nfa_epsilon_closure_matcher #(
	parameter int MAX_TRANSITIONS = nfaec_pkg::MAX_TRANSITIONS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// config write port
	input  logic                                   cfg_we,
	input  logic [nfaec_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [nfaec_pkg::CFG_W-1:0]            cfg_wdata,
	// input items
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [1:0] action, [9:2] symbol, [14:10] source state, [19:15] target state, [23:20] zero
	input  logic [nfaec_pkg::S_TDATA_W-1:0]        s_tdata,
	// result items
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [0] accepted, [32:1] active_set, [33] table_full, [42:34] transition_total,
	// [47:43] zero
	output logic [nfaec_pkg::M_TDATA_W-1:0]        m_tdata
);

	localparam int AW = $clog2(MAX_TRANSITIONS);
	localparam int CW = $clog2(MAX_TRANSITIONS + 1);
	localparam int SW = nfaec_pkg::STATE_W;
	localparam int YW = nfaec_pkg::SYMBOL_W;
	localparam int NW = nfaec_pkg::SET_W;

	nfaec_pkg::state_t state_q;
	nfaec_pkg::phase_t phase_q;

	logic [NW-1:0]                    start_q, accept_q;
	logic [nfaec_pkg::SCNT_W-1:0]     scnt_q;
	logic [CW-1:0]                    cnt_q;
	logic [CW-1:0]                    addr_q;
	logic                             rd_vld_s1;
	logic [NW-1:0]                    set_q, reach_q, cur_q;
	logic                             chg_q;
	logic                             refused_q;
	logic [YW-1:0]                    sym_q;
	logic                             m_tvalid_q;
	logic [nfaec_pkg::M_TDATA_W-1:0]  m_tdata_q;

	logic [1:0]                       in_act;
	logic [YW-1:0]                    in_sym;
	logic [SW-1:0]                    in_from, in_to;
	logic                             accept_in;
	logic                             full;
	logic                             wr_en;
	logic [nfaec_pkg::ENTRY_W-1:0]    rdata;
	logic [SW-1:0]                    e_from, e_to;
	logic [YW-1:0]                    e_sym;
	logic [NW-1:0]                    live;
	logic [NW-1:0]                    shown;
	logic                             pass_end;
	logic                             out_free;

	assign in_act  = s_tdata[1:0];
	assign in_sym  = s_tdata[9:2];
	assign in_from = s_tdata[14:10];
	assign in_to   = s_tdata[19:15];

	assign s_tready  = (state_q == nfaec_pkg::S_IDLE);
	assign accept_in = s_tvalid && s_tready;
	assign full      = (cnt_q == CW'(MAX_TRANSITIONS));
	assign wr_en     = accept_in && (in_act == nfaec_pkg::ACT_ADD) && !full;

	assign live     = nfaec_pkg::live_mask(scnt_q);
	assign shown    = cur_q & live;
	assign pass_end = (addr_q == cnt_q) && !rd_vld_s1;
	assign out_free = !m_tvalid_q || m_tready;

	assign e_from = rdata[nfaec_pkg::ENTRY_W-1 -: SW];
	assign e_sym  = rdata[SW +: YW];
	assign e_to   = rdata[SW-1:0];

	nfaec_ram #(
		.WIDTH(nfaec_pkg::ENTRY_W),
		.DEPTH(MAX_TRANSITIONS)
	) u_list (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({in_from, in_sym, in_to}),
		.raddr (addr_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			accept_q <= '0;
			scnt_q   <= nfaec_pkg::SCNT_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				nfaec_pkg::REG_START_MASK:  start_q  <= cfg_wdata;
				nfaec_pkg::REG_ACCEPT_MASK: accept_q <= cfg_wdata;
				nfaec_pkg::REG_STATE_COUNT: scnt_q   <= cfg_wdata[nfaec_pkg::SCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nfaec_pkg::S_IDLE;
			phase_q    <= nfaec_pkg::PH_CLOS1;
			cnt_q      <= '0;
			addr_q     <= '0;
			rd_vld_s1  <= 1'b0;
			cur_q      <= '0;
			chg_q      <= 1'b0;
			refused_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == nfaec_pkg::S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				nfaec_pkg::S_IDLE: begin
					if (accept_in) begin
						refused_q <= (in_act == nfaec_pkg::ACT_ADD) && full;
						addr_q    <= '0;
						chg_q     <= 1'b0;
						priority if (in_act == nfaec_pkg::ACT_ADD) begin
							if (!full)
								cnt_q <= cnt_q + CW'(1);
							state_q <= nfaec_pkg::S_OUT;
						end else if (in_act == nfaec_pkg::ACT_BEGIN) begin
							// begin only needs the final closure
							phase_q <= nfaec_pkg::PH_CLOS2;
							state_q <= nfaec_pkg::S_WALK;
						end else if (in_act == nfaec_pkg::ACT_CONSUME &&
								in_sym != nfaec_pkg::EPSILON_SYMBOL) begin
							phase_q <= nfaec_pkg::PH_CLOS1;
							state_q <= nfaec_pkg::S_WALK;
						end else begin
							state_q <= nfaec_pkg::S_OUT;
						end
					end
				end
				nfaec_pkg::S_WALK: begin
					rd_vld_s1 <= (addr_q != cnt_q);
					if (addr_q != cnt_q)
						addr_q <= addr_q + CW'(1);
					if (rd_vld_s1 && phase_q != nfaec_pkg::PH_STEP &&
							e_sym == nfaec_pkg::EPSILON_SYMBOL &&
							set_q[e_from] && live[e_to] && !set_q[e_to])
						chg_q <= 1'b1;
					if (pass_end) begin
						addr_q <= '0;
						chg_q  <= 1'b0;
						unique case (phase_q)
							nfaec_pkg::PH_CLOS1: begin
								if (!chg_q)
									phase_q <= nfaec_pkg::PH_STEP;
							end
							nfaec_pkg::PH_STEP: begin
								phase_q <= nfaec_pkg::PH_CLOS2;
							end
							nfaec_pkg::PH_CLOS2: begin
								if (!chg_q) begin
									cur_q   <= set_q;
									state_q <= nfaec_pkg::S_OUT;
								end
							end
							default: ;
						endcase
					end
				end
				nfaec_pkg::S_OUT: begin
					if (out_free)
						state_q <= nfaec_pkg::S_IDLE;
				end
				default: state_q <= nfaec_pkg::S_IDLE;
			endcase
		end
	end

	// Working sets: seed on accept, grow while walking, swap in targets after the symbol pass
	always_ff @(posedge clk) begin
		if (accept_in) begin
			sym_q   <= in_sym;
			reach_q <= '0;
			if (in_act == nfaec_pkg::ACT_BEGIN)
				set_q <= start_q & live;
			else
				set_q <= cur_q & live;
		end else if (state_q == nfaec_pkg::S_WALK) begin
			if (pass_end) begin
				if (phase_q == nfaec_pkg::PH_STEP)
					set_q <= reach_q;
			end else if (rd_vld_s1) begin
				if (phase_q == nfaec_pkg::PH_STEP) begin
					if (e_sym == sym_q && set_q[e_from] && live[e_to])
						reach_q[e_to] <= 1'b1;
				end else if (e_sym == nfaec_pkg::EPSILON_SYMBOL && set_q[e_from] &&
						live[e_to]) begin
					set_q[e_to] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nfaec_pkg::S_OUT && out_free)
			m_tdata_q <= {5'b0, nfaec_pkg::TOTAL_W'(cnt_q), refused_q, shown,
				|(shown & accept_q)};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[verif/testbench.sv]
// Self-checking bench for nfa_epsilon_closure_matcher: loads transition lists, runs
// begin and consume items under changing masks and state counts, and checks each result.
// Depends on nfaec_pkg and the matcher RTL; the set predictor lives in this file.
module testbench;
	import nfaec_pkg::*;

	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int ITEM_GOAL = 960;
	localparam int FILL_TARGET = MAX_TRANSITIONS + 8;

	// lowest field last: action sits in bits [1:0]
	typedef struct packed {
		logic [STATE_W-1:0]  dst_state;
		logic [STATE_W-1:0]  src_state;
		logic [SYMBOL_W-1:0] symbol;
		logic [1:0]          action;
	} nfa_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] transition_total;
		logic               table_full;
		logic [SET_W-1:0]   active_set;
		logic               accepted;
	} nfa_status_t;

	typedef struct packed {
		logic [STATE_W-1:0]  src;
		logic [SYMBOL_W-1:0] sym;
		logic [STATE_W-1:0]  dst;
	} arc_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// automaton copy kept by the bench
	arc_t             arc_list [MAX_TRANSITIONS];
	int unsigned      arc_count = 0;
	logic [SET_W-1:0] live_set = '0;
	logic [SET_W-1:0] reg_start = '0;
	logic [SET_W-1:0] reg_accept = '0;
	logic [SCNT_W-1:0] reg_count = 6'd32;
	int               span = 32;
	int               refused_adds = 0;

	nfa_item_t   items_to_send [$];
	nfa_status_t status_due [$];
	nfa_item_t   offered;
	int          items_sent = 0;
	int          items_taken = 0;
	int          adds_sent = 0;
	int          results_seen = 0;
	int          error_count = 0;
	int          phase_count = 0;
	int          src_mode = 0;
	int          sink_mode = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          hold_off = 0;

	nfa_epsilon_closure_matcher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(64'd2000000000);
		$display("Run stalled: %0d of %0d items taken, %0d results pending",
			items_taken, items_sent, status_due.size());
		$display("FAILURE");
		$finish;
	end

	function automatic logic [SET_W-1:0] states_in_use();
		int n;
		n = (reg_count > 6'd32) ? 32 : int'(reg_count);
		if (n >= 32)
			return '1;
		return (32'd1 << n) - 32'd1;
	endfunction

	// Grow the set along epsilon arcs until a full sweep adds nothing
	function automatic logic [SET_W-1:0] eps_reach(input logic [SET_W-1:0] seed,
			input logic [SET_W-1:0] in_use);
		logic [SET_W-1:0] reach;
		logic grew;
		int i;
		reach = seed & in_use;
		grew = 1'b1;
		while (grew) begin
			grew = 1'b0;
			for (i = 0; i < arc_count; i++) begin
				if (arc_list[i].sym == EPSILON_SYMBOL && reach[arc_list[i].src]
						&& in_use[arc_list[i].dst] && !reach[arc_list[i].dst]) begin
					reach[arc_list[i].dst] = 1'b1;
					grew = 1'b1;
				end
			end
		end
		return reach;
	endfunction

	function automatic logic [SET_W-1:0] after_symbol(input logic [SET_W-1:0] from_set,
			input logic [SYMBOL_W-1:0] sym, input logic [SET_W-1:0] in_use);
		logic [SET_W-1:0] closed;
		logic [SET_W-1:0] hit;
		int i;
		closed = eps_reach(from_set, in_use);
		hit = '0;
		for (i = 0; i < arc_count; i++)
			if (arc_list[i].sym == sym && closed[arc_list[i].src] && in_use[arc_list[i].dst])
				hit[arc_list[i].dst] = 1'b1;
		return eps_reach(hit, in_use);
	endfunction

	// Apply one item to the automaton copy and return the status it reports
	function automatic nfa_status_t advance_automaton(input nfa_item_t it);
		nfa_status_t st;
		logic [SET_W-1:0] in_use;
		logic [SET_W-1:0] shown;
		in_use = states_in_use();
		st = '0;
		case (it.action)
			ACT_ADD: begin
				if (arc_count < MAX_TRANSITIONS) begin
					arc_list[arc_count] = '{src: it.src_state, sym: it.symbol, dst: it.dst_state};
					arc_count++;
				end else begin
					st.table_full = 1'b1;
					refused_adds++;
				end
			end
			ACT_BEGIN: live_set = eps_reach(reg_start, in_use);
			ACT_CONSUME: begin
				if (it.symbol != EPSILON_SYMBOL)
					live_set = after_symbol(live_set, it.symbol, in_use);
			end
			default: ;
		endcase
		shown = live_set & in_use;
		st.accepted = |(shown & reg_accept);
		st.active_set = shown;
		st.transition_total = TOTAL_W'(arc_count);
		return st;
	endfunction

	task automatic report_mismatch(input string what, input logic [SET_W-1:0] seen,
			input logic [SET_W-1:0] due);
		error_count++;
		if (error_count <= 30)
			$display("result %0d: %s (seen %h, predicted %h)", results_seen, what, seen, due);
	endtask

	task automatic send_item(input logic [1:0] act, input logic [SYMBOL_W-1:0] sym,
			input logic [STATE_W-1:0] src, input logic [STATE_W-1:0] dst);
		nfa_item_t it;
		it.action = act;
		it.symbol = sym;
		it.src_state = src;
		it.dst_state = dst;
		items_to_send.push_back(it);
		items_sent++;
		if (act == ACT_ADD)
			adds_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_START_MASK: reg_start = value;
			REG_ACCEPT_MASK: reg_accept = value;
			REG_STATE_COUNT: begin
				reg_count = value[SCNT_W-1:0];
				span = (reg_count == 0 || reg_count > 6'd32) ? 32 : int'(reg_count);
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every item is taken and every result is back
	task automatic settle();
		while (!(items_taken == items_sent && status_due.size() == 0))
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [SYMBOL_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return SYMBOL_W'($urandom_range(1, 4));
		if (r < 88)
			return EPSILON_SYMBOL;
		return SYMBOL_W'($urandom());
	endfunction

	task automatic random_add();
		logic [SYMBOL_W-1:0] sym;
		case ($urandom_range(0, 4))
			0: sym = EPSILON_SYMBOL;
			1: sym = SYMBOL_W'($urandom());
			default: sym = SYMBOL_W'($urandom_range(1, 4));
		endcase
		if ($urandom_range(0, 9) < 7)
			send_item(ACT_ADD, sym, STATE_W'($urandom_range(0, span - 1)),
				STATE_W'($urandom_range(0, span - 1)));
		else
			send_item(ACT_ADD, sym, STATE_W'($urandom()), STATE_W'($urandom()));
	endtask

	initial begin : stimulus
		int phase_end;
		int pick;
		int cnt;
		logic [SET_W-1:0] mask;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_START_MASK, 32'h0000_0001);
		write_reg(REG_ACCEPT_MASK, 32'h8000_0000);
		// empty list: begin, epsilon consume, unknown action, consume with nothing to follow
		send_item(ACT_BEGIN, 8'd0, 5'd0, 5'd0);
		send_item(ACT_CONSUME, EPSILON_SYMBOL, 5'd31, 5'd31);
		send_item(ACT_NOP, 8'hFF, 5'd31, 5'd31);
		send_item(ACT_CONSUME, 8'hFF, 5'd0, 5'd0);
		send_item(ACT_ADD, EPSILON_SYMBOL, 5'd0, 5'd1);
		send_item(ACT_ADD, 8'd1, 5'd1, 5'd2);
		send_item(ACT_ADD, EPSILON_SYMBOL, 5'd2, 5'd31);
		send_item(ACT_ADD, 8'hFF, 5'd31, 5'd0);
		send_item(ACT_ADD, 8'hFF, 5'd0, 5'd31);
		send_item(ACT_BEGIN, 8'd0, 5'd0, 5'd0);
		send_item(ACT_CONSUME, 8'd1, 5'd0, 5'd0);
		send_item(ACT_CONSUME, EPSILON_SYMBOL, 5'd0, 5'd0);
		send_item(ACT_CONSUME, 8'hFF, 5'd0, 5'd0);
		send_item(ACT_CONSUME, 8'hFF, 5'd0, 5'd0);
		send_item(ACT_ADD, EPSILON_SYMBOL, 5'd31, 5'd0);
		send_item(ACT_BEGIN, 8'd0, 5'd0, 5'd0);
		send_item(ACT_CONSUME, 8'd7, 5'd0, 5'd0);
		send_item(ACT_NOP, 8'd0, 5'd0, 5'd0);
		settle();
		// no state in use
		write_reg(REG_STATE_COUNT, 32'd0);
		send_item(ACT_BEGIN, 8'd0, 5'd0, 5'd0);
		send_item(ACT_CONSUME, 8'd1, 5'd0, 5'd0);
		settle();
		// targets outside the states in use are skipped
		write_reg(REG_STATE_COUNT, 32'd2);
		send_item(ACT_BEGIN, 8'd0, 5'd0, 5'd0);
		send_item(ACT_CONSUME, 8'd1, 5'd0, 5'd0);
		settle();
		// count above the state limit clamps; spare index is ignored
		write_reg(REG_STATE_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_item(ACT_BEGIN, 8'd0, 5'd0, 5'd0);
		send_item(ACT_CONSUME, 8'd1, 5'd0, 5'd0);

		while (items_sent < ITEM_GOAL) begin
			settle();
			phase_count++;
			src_mode = $urandom_range(0, 1);
			sink_mode = $urandom_range(0, 2);
			case ($urandom_range(0, 9))
				0: cnt = 0;
				1: cnt = 1;
				2: cnt = 63;
				3: cnt = 33;
				4: cnt = 32;
				default: cnt = $urandom_range(2, 32);
			endcase
			write_reg(REG_STATE_COUNT, ($urandom() & ~32'h3F) | cnt);
			case ($urandom_range(0, 4))
				0: mask = '0;
				1: mask = '1;
				2: mask = $urandom();
				default: mask = 32'd1 << $urandom_range(0, span - 1);
			endcase
			write_reg(REG_START_MASK, mask);
			case ($urandom_range(0, 4))
				0: mask = '0;
				1: mask = '1;
				2: mask = $urandom();
				3: mask = $urandom() & $urandom();
				default: mask = (32'd1 << $urandom_range(0, span - 1))
					| (32'd1 << $urandom_range(0, span - 1));
			endcase
			write_reg(REG_ACCEPT_MASK, mask);
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_SPARE, $urandom());
			phase_end = items_sent + $urandom_range(30, 60);
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 24) begin
					random_add();
				end else if (pick < 90) begin
					// one string: begin, then a run of symbols
					send_item(ACT_BEGIN, SYMBOL_W'($urandom()), STATE_W'($urandom()),
						STATE_W'($urandom()));
					repeat ($urandom_range(1, 8))
						send_item(ACT_CONSUME, pick_symbol(), STATE_W'($urandom()),
							STATE_W'($urandom()));
				end else begin
					send_item(2'($urandom_range(1, 3)), SYMBOL_W'($urandom()),
						STATE_W'($urandom()), STATE_W'($urandom()));
				end
			end
		end

		// fill the list past capacity, then run one more string on the full list
		settle();
		while (adds_sent < FILL_TARGET)
			random_add();
		send_item(ACT_BEGIN, 8'd0, 5'd0, 5'd0);
		repeat (4) send_item(ACT_CONSUME, pick_symbol(), 5'd0, 5'd0);
		settle();
		repeat (20) @(posedge clk);

		$display("Ran %0d items over %0d random configurations; %0d results checked.",
			items_sent, phase_count, results_seen);
		$display("Transition list held %0d entries; %0d adds refused when full.",
			arc_count, refused_adds);
		if (error_count == 0 && status_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin : feed_items
		if (s_tvalid && s_tready) begin
			status_due.push_back(advance_automaton(offered));
			items_taken++;
		end
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (items_to_send.size() > 0) begin
				offered = items_to_send.pop_front();
				s_tdata <= {{(S_TDATA_W - $bits(nfa_item_t)){1'b0}}, offered};
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = (src_mode == 0) ? 0 : $urandom_range(1, 25);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : drain_results
		if (hold_off > 0) begin
			hold_off--;
			m_tready <= 1'b0;
		end else begin
			case (sink_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: begin
					hold_off = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 40) : 0;
					m_tready <= (hold_off == 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		nfa_status_t seen;
		nfa_status_t due;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[$bits(nfa_status_t)-1:0];
			results_seen++;
			if (status_due.size() == 0) begin
				report_mismatch("result with no prediction waiting", seen.active_set, '0);
			end else begin
				due = status_due.pop_front();
				if (seen.accepted !== due.accepted)
					report_mismatch("accepted", SET_W'(seen.accepted), SET_W'(due.accepted));
				if (seen.active_set !== due.active_set)
					report_mismatch("active_set", seen.active_set, due.active_set);
				if (seen.table_full !== due.table_full)
					report_mismatch("table_full", SET_W'(seen.table_full),
						SET_W'(due.table_full));
				if (seen.transition_total !== due.transition_total)
					report_mismatch("transition_total", SET_W'(seen.transition_total),
						SET_W'(due.transition_total));
			end
		end
	end

endmodule
